@@ hdl/dce_pkg.sv @@
// dce_pkg: shared constants, tables and types for the damped cosine easing block.
// No dependencies; compiled first.

package dce_pkg;

    localparam int DCE_FRAC_BITS = 16;

    // configuration port
    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_RATE    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGULAR_SPEED = 4'd1;

    // internal fixed point: 30 fraction bits
    localparam int WQ = 30;
    localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
    localparam logic [28:0] LOG2E_Q28   = 29'd387270502;
    localparam logic [29:0] LN2_Q30     = 30'd744261118;
    localparam logic [32:0] TWO_PI_Q30  = 33'd6746518852;
    localparam logic [31:0] PI_Q30      = 32'd3373259426;
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

    // floor(2^18 / 2pi), i.e. 2^48 / TWO_PI_Q30, for the phase reduction
    localparam logic [15:0] RECIP_TWO_PI = 16'((64'd1 << 48) / TWO_PI_Q30);

    // Horner steps: exponential series first, then cosine series
    localparam int EXP_STEPS    = 10;
    localparam int COS_STEPS    = 8;
    localparam int HORNER_STEPS = EXP_STEPS + COS_STEPS;
    localparam int unsigned HORNER_DIV [HORNER_STEPS] = '{
        10, 9, 8, 7, 6, 5, 4, 3, 2, 1,
        240, 182, 132, 90, 56, 30, 12, 2
    };

    typedef struct packed {
        logic advance;   // whole pipeline shifts one stage
        logic load;      // a new word enters stage one
    } dce_ctl_t;

endpackage

@@ hdl/dce_if.sv @@
// dce_if: channel interfaces of the damped cosine easing block.
// Progress input, eased output and configuration write channel; no dependencies.

interface dce_sample_if #(parameter int W = 17) ();
    logic         valid;
    logic         ready;
    logic [W-1:0] progress;

    modport source (output valid, output progress, input ready);
    modport sink   (input valid, input progress, output ready);
endinterface

interface dce_eased_if #(parameter int W = 17) ();
    logic         valid;
    logic         ready;
    logic [W-1:0] eased_value;

    modport source (output valid, output eased_value, input ready);
    modport sink   (input valid, input eased_value, output ready);
endinterface

interface dce_cfg_if #(parameter int IDX_W = 4, parameter int DATA_W = 23) ();
    logic              valid;
    logic              ready;
    logic [IDX_W-1:0]  index;
    logic [DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hdl/dce_core.sv @@
// dce_core: 36-stage arithmetic pipeline computing 1 - |exp(-x*d) * cos(x*w)|.
// Uses dce_pkg; instantiated by damped_cosine_easing_top.

module dce_core
    import dce_pkg::*;
#(
    parameter int FRAC_BITS = DCE_FRAC_BITS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  dce_ctl_t             ctl,
    input  logic [FRAC_BITS:0]   progress,
    input  logic [FRAC_BITS+6:0] decay_rate,
    input  logic [FRAC_BITS+5:0] angular_speed,
    output logic [FRAC_BITS:0]   eased_value,
    output logic                 valid
);

    localparam int MD_W   = 2 * FRAC_BITS + 8;
    localparam int MS_W   = 2 * FRAC_BITS + 7;
    localparam int EK_DLY = 3 * EXP_STEPS + 1;
    localparam int C_DLY  = (3 + 3 * EXP_STEPS) - (6 + 3 * COS_STEPS);
    localparam int DEPTH  = 3 * EXP_STEPS + 6;
    localparam logic [FRAC_BITS:0] ONE_F = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [30:0] HALF_LSB = 31'(1) << (WQ - 1 - FRAC_BITS);

    logic               vld_reg [DEPTH];

    // stage 1
    logic [FRAC_BITS:0] xs;
    logic [MD_W-1:0]    md_reg;
    logic [MS_W-1:0]    ms_reg;
    // stage 2
    logic [FRAC_BITS+37:0] a_wide;
    logic [FRAC_BITS+36:0] phi_wide;
    logic [36:0]        a_q30;
    logic [36:0]        phi_q30;
    logic               ez2_reg;
    logic [63:0]        tprod_reg;
    logic [36:0]        phi2_reg;
    logic [52:0]        qm2_reg;
    // stage 3
    logic [35:0]        t_q30;
    logic [59:0]        uprod_reg;
    logic [36:0]        phi3_reg;
    logic [37:0]        qd_reg;
    logic [6:0]         ek_reg [EK_DLY];
    // stage 4..6, phase folding and square
    logic [36:0]        r0;
    logic [32:0]        r4_next;
    logic [32:0]        r4_reg;
    logic [32:0]        r1;
    logic [30:0]        rf_next;
    logic [30:0]        rf_reg;
    logic [61:0]        sq_reg;
    // Horner engine, three stages a step
    logic [31:0]        z_in        [HORNER_STEPS];
    logic [30:0]        p_in        [HORNER_STEPS];
    logic [62:0]        prod_a_next [HORNER_STEPS];
    logic [62:0]        prod_a_reg  [HORNER_STEPS];
    logic [31:0]        z_a_reg     [HORNER_STEPS];
    logic [31:0]        v_b_next    [HORNER_STEPS];
    logic [63:0]        qm_b_next   [HORNER_STEPS];
    logic [31:0]        v_b_reg     [HORNER_STEPS];
    logic [63:0]        qm_b_reg    [HORNER_STEPS];
    logic [31:0]        z_b_reg     [HORNER_STEPS];
    logic [30:0]        p_c_next    [HORNER_STEPS];
    logic [30:0]        p_c_reg     [HORNER_STEPS];
    logic [31:0]        z_c_reg     [HORNER_STEPS];
    // tail
    logic [30:0]        c_dly_reg   [C_DLY];
    logic [30:0]        e_next;
    logic [30:0]        e_reg;
    logic [30:0]        c_reg;
    logic [61:0]        mprod_reg;
    logic [31:0]        m_q30;
    logic [30:0]        y30;
    logic [30:0]        ysum;
    logic [FRAC_BITS:0] yr;
    logic [FRAC_BITS:0] y_next;
    logic [FRAC_BITS:0] y_reg;

    assign xs       = (progress > ONE_F) ? ONE_F : progress;
    assign a_wide   = {md_reg, {(WQ - FRAC_BITS){1'b0}}};
    assign phi_wide = {ms_reg, {(WQ - FRAC_BITS){1'b0}}};
    assign a_q30    = a_wide[FRAC_BITS+36:FRAC_BITS];
    assign phi_q30  = phi_wide[FRAC_BITS+36:FRAC_BITS];
    assign t_q30    = tprod_reg[63:28];

    // quotient estimate may be one short
    always_comb
    begin
        r0      = phi3_reg - qd_reg[36:0];
        r4_next = (r0 >= 37'(TWO_PI_Q30)) ? 33'(r0 - 37'(TWO_PI_Q30)) : 33'(r0);
        r1      = (r4_reg > 33'(PI_Q30)) ? 33'(TWO_PI_Q30 - r4_reg) : r4_reg;
        rf_next = (r1 > 33'(HALF_PI_Q30)) ? 31'(33'(PI_Q30) - r1) : 31'(r1);
    end

    for (genvar s = 0; s < HORNER_STEPS; s++)
    begin : g_step
        localparam int unsigned N = HORNER_DIV[s];
        localparam logic [32:0] R = 33'((64'd1 << 32) / N);
        logic [31:0] q0;
        logic [31:0] q0n;
        logic [31:0] rem;
        logic [31:0] q;

        if (s == 0)
        begin : g_exp_in
            assign z_in[s] = {2'b00, uprod_reg[59:30]};
            assign p_in[s] = ONE_Q30;
        end
        else if (s == EXP_STEPS)
        begin : g_cos_in
            assign z_in[s] = sq_reg[61:30];
            assign p_in[s] = ONE_Q30;
        end
        else
        begin : g_chain
            assign z_in[s] = z_c_reg[s-1];
            assign p_in[s] = p_c_reg[s-1];
        end

        assign prod_a_next[s] = z_in[s] * p_in[s];
        assign v_b_next[s]    = prod_a_reg[s][61:30];
        assign qm_b_next[s]   = 64'(v_b_next[s] * R);

        // reciprocal quotient, then one correction
        assign q0  = qm_b_reg[s][63:32];
        assign q0n = 32'(q0 * N);
        assign rem = v_b_reg[s] - q0n;
        assign q   = (rem >= N) ? q0 + 32'd1 : q0;
        assign p_c_next[s] = (q >= 32'(ONE_Q30)) ? 31'd0 : 31'(32'(ONE_Q30) - q);
    end

    always_comb
    begin
        e_next = ek_reg[EK_DLY-1][6] ? 31'd0
                                     : (p_c_reg[EXP_STEPS-1] >> ek_reg[EK_DLY-1][5:0]);
        m_q30  = mprod_reg[61:30];
        y30    = (m_q30 >= 32'(ONE_Q30)) ? 31'd0 : 31'(32'(ONE_Q30) - m_q30);
        ysum   = y30 + HALF_LSB;
        yr     = ysum[WQ:WQ-FRAC_BITS];
        y_next = (yr > ONE_F) ? ONE_F : yr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (ctl.advance)
        begin
            vld_reg[0] <= ctl.load;
            for (int i = 1; i < DEPTH; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.advance)
        begin
            md_reg    <= MD_W'(xs * decay_rate);
            ms_reg    <= MS_W'(xs * angular_speed);

            ez2_reg   <= (a_q30[36:35] != 2'b00);
            tprod_reg <= a_q30[34:0] * LOG2E_Q28;
            phi2_reg  <= phi_q30;
            qm2_reg   <= phi_q30 * RECIP_TWO_PI;

            uprod_reg <= t_q30[29:0] * LN2_Q30;
            ek_reg[0] <= {ez2_reg, t_q30[35:30]};
            for (int i = 1; i < EK_DLY; i++)
            begin
                ek_reg[i] <= ek_reg[i-1];
            end
            phi3_reg  <= phi2_reg;
            qd_reg    <= qm2_reg[52:48] * TWO_PI_Q30;

            r4_reg    <= r4_next;
            rf_reg    <= rf_next;
            sq_reg    <= rf_reg * rf_reg;

            for (int s = 0; s < HORNER_STEPS; s++)
            begin
                prod_a_reg[s] <= prod_a_next[s];
                z_a_reg[s]    <= z_in[s];
                v_b_reg[s]    <= v_b_next[s];
                qm_b_reg[s]   <= qm_b_next[s];
                z_b_reg[s]    <= z_a_reg[s];
                p_c_reg[s]    <= p_c_next[s];
                z_c_reg[s]    <= z_b_reg[s];
            end

            c_dly_reg[0] <= p_c_reg[HORNER_STEPS-1];
            for (int i = 1; i < C_DLY; i++)
            begin
                c_dly_reg[i] <= c_dly_reg[i-1];
            end

            e_reg     <= e_next;
            c_reg     <= c_dly_reg[C_DLY-1];
            mprod_reg <= e_reg * c_reg;
            y_reg     <= y_next;
        end
    end

    assign eased_value = y_reg;
    assign valid       = vld_reg[DEPTH-1];

endmodule

@@ hdl/damped_cosine_easing_top.sv @@
// Channel   Dir   Payload                       Handshake
// sample    in    progress  [F:0]  Q1.F          valid/ready
// eased     out   eased_value [F:0] Q1.F         valid/ready
// cfg       in    index [3:0], data [F+6:0]      valid/ready, ready always high
//
// One word per cycle sustained while the skid register is empty.
// Depth is set by the 10 exponential Horner steps (multiply, reciprocal multiply,
// correction), plus three stages ahead of them and three behind.
// Reset clears valid bits and loads both rates with 1.0.
// A one-word skid behind the pipeline lets input continue while a result is held;
// ready drops only when both the output and skid registers are full.
//
// Uses dce_pkg, dce_if interfaces and dce_core.

module damped_cosine_easing_top
    import dce_pkg::*;
#(
    parameter int FRAC_BITS = DCE_FRAC_BITS
)
(
    input  logic        clk,
    input  logic        rst_n,
    dce_sample_if.sink  sample,
    dce_eased_if.source eased,
    dce_cfg_if.sink     cfg
);

    localparam int DECAY_W = FRAC_BITS + 7;
    localparam int SPEED_W = FRAC_BITS + 6;

    logic [DECAY_W-1:0] decay_rate_reg;
    logic [SPEED_W-1:0] angular_speed_reg;
    dce_ctl_t           ctl;
    logic [FRAC_BITS:0] core_y;
    logic               core_vld;
    logic               take;
    logic               push;
    logic               out_vld_reg;
    logic [FRAC_BITS:0] out_data_reg;
    logic               skid_vld_reg;
    logic [FRAC_BITS:0] skid_data_reg;

    assign cfg.ready    = 1'b1;
    assign sample.ready = !skid_vld_reg;
    assign ctl.advance  = !skid_vld_reg;
    assign ctl.load     = sample.valid && sample.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decay_rate_reg    <= DECAY_W'(1) << FRAC_BITS;
            angular_speed_reg <= SPEED_W'(1) << FRAC_BITS;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_DECAY_RATE:    decay_rate_reg    <= cfg.data[DECAY_W-1:0];
                CFG_ANGULAR_SPEED: angular_speed_reg <= cfg.data[SPEED_W-1:0];
                default:           ;
            endcase
        end
    end

    dce_core #(
        .FRAC_BITS (FRAC_BITS)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .progress      (sample.progress),
        .decay_rate    (decay_rate_reg),
        .angular_speed (angular_speed_reg),
        .eased_value   (core_y),
        .valid         (core_vld)
    );

    // output register free or being emptied
    assign take = !out_vld_reg || eased.ready;
    assign push = ctl.advance && core_vld;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (take)
        begin
            if (skid_vld_reg)
            begin
                out_vld_reg  <= 1'b1;
                skid_vld_reg <= 1'b0;
            end
            else
            begin
                out_vld_reg <= push;
            end
        end
        else if (push)
        begin
            skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            if (skid_vld_reg)
            begin
                out_data_reg <= skid_data_reg;
            end
            else if (push)
            begin
                out_data_reg <= core_y;
            end
        end
        else if (push)
        begin
            skid_data_reg <= core_y;
        end
    end

    assign eased.valid       = out_vld_reg;
    assign eased.eased_value = out_data_reg;

endmodule

@@ hdl/dce_checker.sv @@
// dce_checker: port-level assertions for damped_cosine_easing_top, with its bind.
// No package dependency; watches the top level's channel signals.

module dce_checker #(
    parameter int FRAC_BITS = 16
)
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [FRAC_BITS:0] eased_value
);

    localparam logic [FRAC_BITS:0] ONE_F = {1'b1, {FRAC_BITS{1'b0}}};

    logic [7:0] pending_reg;

    // words accepted and not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 8'd0;
        end
        else
        begin
            pending_reg <= pending_reg + 8'(in_valid && in_ready) - 8'(out_valid && out_ready);
        end
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(eased_value))
        else $error("held result changed");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> eased_value <= ONE_F)
        else $error("result above one");

    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |-> pending_reg != 8'd0)
        else $error("result without an accepted word");

    // skid can only fill behind a held output
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(out_valid) |-> in_ready)
        else $error("input stalled with empty output");

endmodule

bind damped_cosine_easing_top dce_checker #(
    .FRAC_BITS (FRAC_BITS)
) u_dce_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (sample.valid),
    .in_ready    (sample.ready),
    .out_valid   (eased.valid),
    .out_ready   (eased.ready),
    .eased_value (eased.eased_value)
);
